### rtl/core/gbts_pkg.sv
package gbts_pkg;

  // Fixed field widths of the command and result beats.
  localparam int CMD_W    = 3;
  localparam int POS_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 2;
  localparam int CAP_W    = 13;

  // Capacity after reset, before any clamp to the store depth.
  localparam int CAP_RESET = 4096;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_DELETE     = 3'd1,
    CMD_READ       = 3'd2,
    CMD_LINE_START = 3'd3,
    CMD_LINE_END   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOVE,
    ST_MOVE_WR,
    ST_INSERT,
    ST_DELETE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_RDBYTE,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage

### rtl/core/gbts_ram.sv
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/gbts_ctrl.sv
module gbts_ctrl #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gbts_pkg::CMD_W-1:0]    in_cmd,
  input  logic [gbts_pkg::POS_W-1:0]    in_position,
  input  logic [gbts_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [gbts_pkg::POS_W-1:0]    in_count,
  input  logic                          cap_load,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] cap_val,
  output logic                          busy,
  output logic                          out_strobe,
  output logic [gbts_pkg::STAT_W-1:0]   out_status,
  output logic [gbts_pkg::BYTE_W-1:0]   out_byte_out,
  output logic [gbts_pkg::POS_W-1:0]    out_found_position,
  output logic [gbts_pkg::POS_W-1:0]    out_content_length
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int LW  = $clog2(STORE_DEPTH + 1);
  localparam int PW  = gbts_pkg::POS_W;
  localparam int XW  = (LW > PW) ? LW : PW;
  localparam int CAP_RST = (STORE_DEPTH < gbts_pkg::CAP_RESET) ?
                           STORE_DEPTH : gbts_pkg::CAP_RESET;

  gbts_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] gs_r, gs_nxt;
  logic [LW-1:0] ge_r, ge_nxt;
  logic [LW-1:0] p_r, p_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [gbts_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [PW-1:0]               cin_r, cin_nxt;
  logic [gbts_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic [gbts_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [gbts_pkg::BYTE_W-1:0] bout_r, bout_nxt;
  logic [LW-1:0]               found_r, found_nxt;

  logic [LW-1:0] len;
  logic [XW-1:0] len_x, pos_x, cin_x, rem_x;
  logic          move_left;
  logic          scan_back;
  logic [LW-1:0] q;
  logic [LW-1:0] phys;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [gbts_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  assign len       = cap_val - (ge_r - gs_r);
  assign len_x     = XW'(len);
  assign pos_x     = XW'(pos_r);
  assign cin_x     = XW'(cin_r);
  assign rem_x     = len_x - pos_x;
  assign move_left = p_r < gs_r;
  assign scan_back = (cmd_r == gbts_pkg::CMD_LINE_START);

  // Logical text position to store index: the one adder and compare shared
  // by every byte read of the read and line-search commands.
  assign q    = scan_back ? (p_r - LW'(1)) : p_r;
  assign phys = (q < gs_r) ? q : (ge_r + (q - gs_r));

  gbts_ram #(
    .WIDTH(gbts_pkg::BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbts_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = gbts_pkg::ST_DECODE;
        end
      end
      gbts_pkg::ST_DECODE: begin
        state_nxt = gbts_pkg::ST_DONE;
        case (cmd_r)
          gbts_pkg::CMD_INSERT: begin
            if (pos_x <= len_x && gs_r != ge_r) begin
              state_nxt = gbts_pkg::ST_MOVE;
            end
          end
          gbts_pkg::CMD_DELETE: begin
            if (pos_x < len_x) begin
              state_nxt = gbts_pkg::ST_MOVE;
            end
          end
          gbts_pkg::CMD_READ: begin
            if (pos_x < len_x) begin
              state_nxt = gbts_pkg::ST_RDBYTE;
            end
          end
          gbts_pkg::CMD_LINE_START, gbts_pkg::CMD_LINE_END: begin
            if (pos_x <= len_x) begin
              state_nxt = gbts_pkg::ST_SCAN;
            end
          end
          default: state_nxt = gbts_pkg::ST_DONE;
        endcase
      end
      gbts_pkg::ST_MOVE: begin
        if (p_r == gs_r) begin
          state_nxt = (cmd_r == gbts_pkg::CMD_INSERT) ? gbts_pkg::ST_INSERT :
                                                        gbts_pkg::ST_DELETE;
        end else begin
          state_nxt = gbts_pkg::ST_MOVE_WR;
        end
      end
      gbts_pkg::ST_MOVE_WR:  state_nxt = gbts_pkg::ST_MOVE;
      gbts_pkg::ST_INSERT:   state_nxt = gbts_pkg::ST_DONE;
      gbts_pkg::ST_DELETE:   state_nxt = gbts_pkg::ST_DONE;
      gbts_pkg::ST_SCAN: begin
        if (scan_back ? (p_r == '0) : (p_r >= len)) begin
          state_nxt = gbts_pkg::ST_DONE;
        end else begin
          state_nxt = gbts_pkg::ST_SCAN_CHK;
        end
      end
      gbts_pkg::ST_SCAN_CHK: begin
        state_nxt = (ram_rdata == gbts_pkg::NEWLINE) ? gbts_pkg::ST_DONE :
                                                      gbts_pkg::ST_SCAN;
      end
      gbts_pkg::ST_RDBYTE:   state_nxt = gbts_pkg::ST_RDWAIT;
      gbts_pkg::ST_RDWAIT:   state_nxt = gbts_pkg::ST_DONE;
      gbts_pkg::ST_DONE:     state_nxt = gbts_pkg::ST_IDLE;
      default:               state_nxt = gbts_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    gs_nxt     = gs_r;
    ge_nxt     = ge_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    cin_nxt    = cin_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    bout_nxt   = bout_r;
    found_nxt  = found_r;
    case (state_r)
      gbts_pkg::ST_IDLE: begin
        if (cap_load) begin
          gs_nxt = '0;
          ge_nxt = cap_val;
        end
        if (start) begin
          cmd_nxt  = in_cmd;
          pos_nxt  = in_position;
          cin_nxt  = in_count;
          data_nxt = in_data_byte;
        end
      end
      gbts_pkg::ST_DECODE: begin
        status_nxt = gbts_pkg::STAT_OK;
        bout_nxt   = '0;
        found_nxt  = '0;
        p_nxt      = LW'(pos_x);
        cnt_nxt    = (cin_x > rem_x) ? LW'(rem_x) : LW'(cin_x);
        case (cmd_r)
          gbts_pkg::CMD_INSERT: begin
            if (pos_x > len_x) begin
              status_nxt = gbts_pkg::STAT_RANGE;
            end else if (gs_r == ge_r) begin
              status_nxt = gbts_pkg::STAT_FULL;
            end
          end
          gbts_pkg::CMD_DELETE, gbts_pkg::CMD_READ: begin
            if (pos_x >= len_x) begin
              status_nxt = gbts_pkg::STAT_RANGE;
            end
          end
          gbts_pkg::CMD_LINE_START, gbts_pkg::CMD_LINE_END: begin
            if (pos_x > len_x) begin
              status_nxt = gbts_pkg::STAT_RANGE;
            end
          end
          default: status_nxt = gbts_pkg::STAT_OK;
        endcase
      end
      gbts_pkg::ST_MOVE_WR: begin
        if (move_left) begin
          gs_nxt = gs_r - LW'(1);
          ge_nxt = ge_r - LW'(1);
        end else begin
          gs_nxt = gs_r + LW'(1);
          ge_nxt = ge_r + LW'(1);
        end
      end
      gbts_pkg::ST_INSERT: gs_nxt = gs_r + LW'(1);
      gbts_pkg::ST_DELETE: ge_nxt = ge_r + cnt_r;
      gbts_pkg::ST_SCAN: begin
        if (scan_back ? (p_r == '0) : (p_r >= len)) begin
          found_nxt = p_r;
        end
      end
      gbts_pkg::ST_SCAN_CHK: begin
        if (ram_rdata == gbts_pkg::NEWLINE) begin
          found_nxt = p_r;
        end else if (scan_back) begin
          p_nxt = p_r - LW'(1);
        end else begin
          p_nxt = p_r + LW'(1);
        end
      end
      gbts_pkg::ST_RDWAIT: bout_nxt = ram_rdata;
      default: ;
    endcase
  end

  // Outputs and store port control.
  always_comb begin
    busy       = (state_r != gbts_pkg::ST_IDLE);
    out_strobe = (state_r == gbts_pkg::ST_DONE);
    ram_we     = 1'b0;
    ram_waddr  = gs_r[AW-1:0];
    ram_wdata  = data_r;
    ram_raddr  = phys[AW-1:0];
    case (state_r)
      gbts_pkg::ST_MOVE: begin
        ram_raddr = move_left ? AW'(gs_r - LW'(1)) : ge_r[AW-1:0];
      end
      gbts_pkg::ST_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = move_left ? AW'(ge_r - LW'(1)) : gs_r[AW-1:0];
        ram_wdata = ram_rdata;
      end
      gbts_pkg::ST_INSERT: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign out_status         = status_r;
  assign out_byte_out       = bout_r;
  assign out_found_position = PW'(found_r);
  assign out_content_length = PW'(len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbts_pkg::ST_IDLE;
      gs_r    <= '0;
      ge_r    <= LW'(CAP_RST);
    end else begin
      state_r <= state_nxt;
      gs_r    <= gs_nxt;
      ge_r    <= ge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    cin_r    <= cin_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
    bout_r   <= bout_nxt;
    found_r  <= found_nxt;
  end

endmodule

### rtl/core/gap_buffer_text_store.sv
// Gap-buffer text store. Text is held in a byte RAM with one read port and
// one write port as a front part, a gap and a back part. A command beat is
// taken when start is high and busy is low; busy then stays high until the
// single result beat, which is shown on the out_ ports for exactly one cycle
// with out_strobe high. The receiver cannot stall, so the result must be
// captured in that cycle. The byte RAM has a registered read, and the gap
// copy loop moves one byte per read state and write state, so an insert or
// delete takes longer the farther the gap moves, and a line-start or
// line-end search takes longer the more bytes it scans. Writing capacity
// (register 0 at byte address 0) while the controller is idle empties the
// text; values of 0 count as 1 and values above STORE_DEPTH are clamped.
// Store contents are undefined after reset and no clearing pass is run,
// since only written bytes are ever read.
module gap_buffer_text_store #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [gbts_pkg::CMD_W-1:0]  in_cmd,
  input  logic [gbts_pkg::POS_W-1:0]  in_position,
  input  logic [gbts_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [gbts_pkg::POS_W-1:0]  in_count,
  output logic                        out_strobe,
  output logic [gbts_pkg::STAT_W-1:0] out_status,
  output logic [gbts_pkg::BYTE_W-1:0] out_byte_out,
  output logic [gbts_pkg::POS_W-1:0]  out_found_position,
  output logic [gbts_pkg::POS_W-1:0]  out_content_length,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int LW = $clog2(STORE_DEPTH + 1);
  localparam int XW = (LW > gbts_pkg::CAP_W) ? LW : gbts_pkg::CAP_W;
  localparam int CAP_RST = (STORE_DEPTH < gbts_pkg::CAP_RESET) ?
                           STORE_DEPTH : gbts_pkg::CAP_RESET;

  logic [LW-1:0] cap_r, cap_nxt;
  logic          cap_wr;
  logic [XW-1:0] wr_val;

  // The only register sits at word 0; address bit 2 picks it.
  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && pready && !paddr[2];
  assign wr_val = XW'(pwdata[gbts_pkg::CAP_W-1:0]);
  assign prdata = paddr[2] ? 32'd0 : 32'(cap_r);

  // Clamp the written capacity into the range the store can hold.
  always_comb begin
    cap_nxt = cap_r;
    if (cap_wr) begin
      if (wr_val == '0) begin
        cap_nxt = LW'(1);
      end else if (wr_val > XW'(STORE_DEPTH)) begin
        cap_nxt = LW'(STORE_DEPTH);
      end else begin
        cap_nxt = LW'(wr_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= LW'(CAP_RST);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // The gap registers are reloaded in the same edge as the capacity when the
  // controller is idle, so the controller sees the new value on its load input.
  gbts_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_cmd            (in_cmd),
    .in_position       (in_position),
    .in_data_byte      (in_data_byte),
    .in_count          (in_count),
    .cap_load          (cap_wr),
    .cap_val           (cap_wr ? cap_nxt : cap_r),
    .busy              (busy),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_byte_out      (out_byte_out),
    .out_found_position(out_found_position),
    .out_content_length(out_content_length)
  );

endmodule

### rtl/core/gbts_checker.sv
module gbts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [1:0] out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe)
    else $error("block did not return to idle after its result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_status <= gbts_pkg::STAT_RANGE)
    else $error("undefined status code");

endmodule

bind gap_buffer_text_store gbts_checker u_gbts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_status(out_status)
);
